>>> src/slt_pkg.sv
package slt_pkg;

  localparam int MAX_TEXT_BYTES_DEF = 65536;

  localparam logic [5:0] K_VAR     = 6'd0;
  localparam logic [5:0] K_IF      = 6'd1;
  localparam logic [5:0] K_ELSE    = 6'd2;
  localparam logic [5:0] K_TRUE    = 6'd3;
  localparam logic [5:0] K_FALSE   = 6'd4;
  localparam logic [5:0] K_IDENT   = 6'd5;
  localparam logic [5:0] K_TYPE    = 6'd6;
  localparam logic [5:0] K_NUMBER  = 6'd7;
  localparam logic [5:0] K_STRING  = 6'd8;
  localparam logic [5:0] K_LPAREN  = 6'd9;
  localparam logic [5:0] K_RPAREN  = 6'd10;
  localparam logic [5:0] K_LBRACE  = 6'd11;
  localparam logic [5:0] K_RBRACE  = 6'd12;
  localparam logic [5:0] K_LBRACK  = 6'd13;
  localparam logic [5:0] K_RBRACK  = 6'd14;
  localparam logic [5:0] K_COMMA   = 6'd15;
  localparam logic [5:0] K_SEMI    = 6'd16;
  localparam logic [5:0] K_COLON   = 6'd17;
  localparam logic [5:0] K_ASSIGN  = 6'd18;
  localparam logic [5:0] K_DEFINE  = 6'd19;
  localparam logic [5:0] K_EQ      = 6'd20;
  localparam logic [5:0] K_NE      = 6'd21;
  localparam logic [5:0] K_LT      = 6'd22;
  localparam logic [5:0] K_GT      = 6'd23;
  localparam logic [5:0] K_LE      = 6'd24;
  localparam logic [5:0] K_GE      = 6'd25;
  localparam logic [5:0] K_PLUS    = 6'd26;
  localparam logic [5:0] K_MINUS   = 6'd27;
  localparam logic [5:0] K_STAR    = 6'd28;
  localparam logic [5:0] K_SLASH   = 6'd29;
  localparam logic [5:0] K_AND     = 6'd30;
  localparam logic [5:0] K_OR      = 6'd31;
  localparam logic [5:0] K_NOT     = 6'd32;
  localparam logic [5:0] K_UNKNOWN = 6'd33;

  typedef struct packed {
    logic        is_token;
    logic [5:0]  kind;
    logic [15:0] offset;
    logic [16:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic [16:0] number;
    logic        unterm;
    logic        eot;
  } result_t;

  // up to three results caused by one byte
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } bundle_t;

endpackage

>>> src/slt_front.sv
module slt_front #(
  parameter int MAX_TEXT_BYTES = slt_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  input  logic             last_byte,
  output slt_pkg::bundle_t bundle
);

  localparam int PW = $clog2(MAX_TEXT_BYTES);
  localparam int CW = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TEXT_BYTES);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_TEXT_BYTES - 1);

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_ESIGN, MODE_EDIG,
    MODE_STR, MODE_ESC, MODE_PEND, MODE_CMT
  } mode_t;

  mode_t           mode, mode_next;
  logic [7:0]      pending_char, pending_char_next;
  logic [PW-1:0]   token_start, token_start_next;
  logic [CW-1:0]   token_len_count, token_len_count_next;
  logic [15:0]     token_start_column, token_start_column_next;
  logic [4:0][7:0] keyword_prefix, keyword_prefix_next;
  logic            starts_upper, starts_upper_next;
  logic [PW-1:0]   byte_position, byte_position_next;
  logic [15:0]     line_count, line_count_next;
  logic [15:0]     column_count, column_count_next;
  logic [CW-1:0]   tokens_emitted, tokens_emitted_next;

  logic            used;
  logic [1:0]      n;
  logic [5:0]      pk;
  logic [2:0]      len3;
  slt_pkg::result_t [2:0] res;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic id_start(input logic [7:0] c);
    return is_upper(c) || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "(":     k = slt_pkg::K_LPAREN;
      ")":     k = slt_pkg::K_RPAREN;
      "{":     k = slt_pkg::K_LBRACE;
      "}":     k = slt_pkg::K_RBRACE;
      "[":     k = slt_pkg::K_LBRACK;
      "]":     k = slt_pkg::K_RBRACK;
      ",":     k = slt_pkg::K_COMMA;
      ";":     k = slt_pkg::K_SEMI;
      ":":     k = slt_pkg::K_COLON;
      "=":     k = slt_pkg::K_ASSIGN;
      "<":     k = slt_pkg::K_LT;
      ">":     k = slt_pkg::K_GT;
      "+":     k = slt_pkg::K_PLUS;
      "-":     k = slt_pkg::K_MINUS;
      "*":     k = slt_pkg::K_STAR;
      "/":     k = slt_pkg::K_SLASH;
      "!":     k = slt_pkg::K_NOT;
      default: k = slt_pkg::K_UNKNOWN;
    endcase
    return k;
  endfunction

  // zero when the pair forms no operator
  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = '0;
    if (p == ":" && c == "=") k = slt_pkg::K_DEFINE;
    if (p == "=" && c == "=") k = slt_pkg::K_EQ;
    if (p == "!" && c == "=") k = slt_pkg::K_NE;
    if (p == "<" && c == "=") k = slt_pkg::K_LE;
    if (p == ">" && c == "=") k = slt_pkg::K_GE;
    if (p == "&" && c == "&") k = slt_pkg::K_AND;
    if (p == "|" && c == "|") k = slt_pkg::K_OR;
    return k;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [4:0][7:0] kp, input logic [2:0] len,
                                            input logic up);
    logic [5:0] k;
    k = up ? slt_pkg::K_TYPE : slt_pkg::K_IDENT;
    if (len == 3'd3 && kp[0] == "v" && kp[1] == "a" && kp[2] == "r") k = slt_pkg::K_VAR;
    if (len == 3'd2 && kp[0] == "i" && kp[1] == "f") k = slt_pkg::K_IF;
    if (len == 3'd4 && kp[0] == "e" && kp[1] == "l" && kp[2] == "s" && kp[3] == "e")
      k = slt_pkg::K_ELSE;
    if (len == 3'd4 && kp[0] == "t" && kp[1] == "r" && kp[2] == "u" && kp[3] == "e")
      k = slt_pkg::K_TRUE;
    if (len == 3'd5 && kp[0] == "f" && kp[1] == "a" && kp[2] == "l" && kp[3] == "s" &&
        kp[4] == "e")
      k = slt_pkg::K_FALSE;
    return k;
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v < CNT_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic slt_pkg::result_t mk(input logic [5:0] kind, input logic [CW-1:0] len,
                                          input logic unterm, input logic [PW-1:0] ts,
                                          input logic [15:0] ln, input logic [15:0] tsc,
                                          input logic [CW-1:0] num);
    slt_pkg::result_t r;
    r.is_token = 1'b1;
    r.kind     = kind;
    r.offset   = 16'(ts);
    r.length   = 17'(len);
    r.line     = ln;
    r.column   = tsc;
    r.number   = 17'(num);
    r.unterm   = unterm;
    r.eot      = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_next               = mode;
    pending_char_next       = pending_char;
    token_start_next        = token_start;
    token_len_count_next    = token_len_count;
    token_start_column_next = token_start_column;
    keyword_prefix_next     = keyword_prefix;
    starts_upper_next       = starts_upper;
    byte_position_next      = byte_position;
    line_count_next         = line_count;
    column_count_next       = column_count;
    tokens_emitted_next     = tokens_emitted;
    used = 1'b1;
    n    = 2'd0;
    res  = '0;
    len3 = 3'd0;
    pk   = pair_kind(pending_char, text_byte);

    // resolve a held operator byte against this one
    if (mode == MODE_PEND) begin
      if (pending_char == "-" && is_digit(text_byte)) begin
        mode_next = MODE_INT;
      end else if (pk != '0) begin
        token_len_count_next = sat_inc(token_len_count_next);
        column_count_next    = inc16(column_count_next);
        res[n] = mk(pk, token_len_count_next, 1'b0, token_start_next, line_count_next,
                    token_start_column_next, tokens_emitted_next);
        n = n + 2'd1;
        tokens_emitted_next = sat_inc(tokens_emitted_next);
        mode_next = MODE_IDLE;
      end else begin
        res[n] = mk(single_kind(pending_char), token_len_count_next, 1'b0,
                    token_start_next, line_count_next, token_start_column_next,
                    tokens_emitted_next);
        n = n + 2'd1;
        tokens_emitted_next = sat_inc(tokens_emitted_next);
        mode_next = MODE_IDLE;
        used = 1'b0;
      end
    end

    len3 = (token_len_count_next < CW'(8)) ? token_len_count_next[2:0] : 3'd0;
    unique case (mode_next)
      MODE_IDENT: begin
        if (id_start(text_byte) || is_digit(text_byte)) begin
          if (token_len_count_next < CW'(5))
            keyword_prefix_next[token_len_count_next[2:0]] = text_byte;
          token_len_count_next = sat_inc(token_len_count_next);
          column_count_next    = inc16(column_count_next);
        end else begin
          res[n] = mk(ident_kind(keyword_prefix_next, len3, starts_upper_next),
                      token_len_count_next, 1'b0, token_start_next, line_count_next,
                      token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
          mode_next = MODE_IDLE;
          used = 1'b0;
        end
      end
      MODE_INT, MODE_FRAC, MODE_ESIGN, MODE_EDIG: begin
        priority if (is_digit(text_byte)) begin
          if (mode_next == MODE_ESIGN) mode_next = MODE_EDIG;
          token_len_count_next = sat_inc(token_len_count_next);
          column_count_next    = inc16(column_count_next);
        end else if (text_byte == "." && mode_next == MODE_INT) begin
          mode_next = MODE_FRAC;
          token_len_count_next = sat_inc(token_len_count_next);
          column_count_next    = inc16(column_count_next);
        end else if ((text_byte == "e" || text_byte == "E") &&
                     (mode_next == MODE_INT || mode_next == MODE_FRAC)) begin
          mode_next = MODE_ESIGN;
          token_len_count_next = sat_inc(token_len_count_next);
          column_count_next    = inc16(column_count_next);
        end else if ((text_byte == "+" || text_byte == "-") && mode_next == MODE_ESIGN) begin
          mode_next = MODE_EDIG;
          token_len_count_next = sat_inc(token_len_count_next);
          column_count_next    = inc16(column_count_next);
        end else begin
          res[n] = mk(slt_pkg::K_NUMBER, token_len_count_next, 1'b0, token_start_next,
                      line_count_next, token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
          mode_next = MODE_IDLE;
          used = 1'b0;
        end
      end
      MODE_STR: begin
        token_len_count_next = sat_inc(token_len_count_next);
        column_count_next    = inc16(column_count_next);
        if (text_byte == "\"") begin
          res[n] = mk(slt_pkg::K_STRING, token_len_count_next, 1'b0, token_start_next,
                      line_count_next, token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
          mode_next = MODE_IDLE;
        end else if (text_byte == "\\") begin
          mode_next = MODE_ESC;
        end
      end
      MODE_ESC: begin
        token_len_count_next = sat_inc(token_len_count_next);
        mode_next = MODE_STR;
      end
      MODE_CMT: begin
        if (text_byte == 8'h0A) begin
          line_count_next   = inc16(line_count_next);
          column_count_next = 16'd1;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        if (used && mode_next == MODE_IDLE && n == 2'd0) used = 1'b0;
      end
    endcase

    // byte opens something new
    if (!used) begin
      priority if (is_space(text_byte)) begin
        if (text_byte == 8'h0A) begin
          line_count_next   = inc16(line_count_next);
          column_count_next = 16'd1;
        end else begin
          column_count_next = inc16(column_count_next);
        end
      end else if (text_byte == "#") begin
        mode_next = MODE_CMT;
      end else begin
        token_start_next        = byte_position;
        token_start_column_next = column_count_next;
        token_len_count_next    = CW'(1);
        column_count_next       = inc16(column_count_next);
        priority if (id_start(text_byte)) begin
          keyword_prefix_next    = '0;
          keyword_prefix_next[0] = text_byte;
          starts_upper_next      = is_upper(text_byte);
          mode_next = MODE_IDENT;
        end else if (is_digit(text_byte)) begin
          mode_next = MODE_INT;
        end else if (text_byte == "-" || text_byte == ":" || text_byte == "=" ||
                     text_byte == "!" || text_byte == "<" || text_byte == ">" ||
                     text_byte == "&" || text_byte == "|") begin
          pending_char_next = text_byte;
          mode_next = MODE_PEND;
        end else if (text_byte == "\"") begin
          mode_next = MODE_STR;
        end else begin
          res[n] = mk(single_kind(text_byte), CW'(1), 1'b0, token_start_next,
                      line_count_next, token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
          mode_next = MODE_IDLE;
        end
      end
    end

    if (byte_position < POS_MAX) byte_position_next = byte_position + 1'b1;

    // flush and close the text
    if (last_byte) begin
      len3 = (token_len_count_next < CW'(8)) ? token_len_count_next[2:0] : 3'd0;
      unique case (mode_next)
        MODE_IDENT: begin
          res[n] = mk(ident_kind(keyword_prefix_next, len3, starts_upper_next),
                      token_len_count_next, 1'b0, token_start_next, line_count_next,
                      token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
        end
        MODE_INT, MODE_FRAC, MODE_ESIGN, MODE_EDIG: begin
          res[n] = mk(slt_pkg::K_NUMBER, token_len_count_next, 1'b0, token_start_next,
                      line_count_next, token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
        end
        MODE_STR, MODE_ESC: begin
          res[n] = mk(slt_pkg::K_STRING, token_len_count_next, 1'b1, token_start_next,
                      line_count_next, token_start_column_next, tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
        end
        MODE_PEND: begin
          res[n] = mk(single_kind(pending_char_next), token_len_count_next, 1'b0,
                      token_start_next, line_count_next, token_start_column_next,
                      tokens_emitted_next);
          n = n + 2'd1;
          tokens_emitted_next = sat_inc(tokens_emitted_next);
        end
        default: ;
      endcase
      res[n] = '0;
      res[n].number = 17'(tokens_emitted_next);
      res[n].eot    = 1'b1;
      n = n + 2'd1;
      mode_next               = MODE_IDLE;
      pending_char_next       = '0;
      token_start_next        = '0;
      token_len_count_next    = '0;
      token_start_column_next = 16'd1;
      keyword_prefix_next     = '0;
      starts_upper_next       = 1'b0;
      byte_position_next      = '0;
      line_count_next         = 16'd1;
      column_count_next       = 16'd1;
      tokens_emitted_next     = '0;
    end
  end

  assign bundle.count = n;
  assign bundle.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      pending_char       <= '0;
      token_start        <= '0;
      token_len_count    <= '0;
      token_start_column <= 16'd1;
      keyword_prefix     <= '0;
      starts_upper       <= 1'b0;
      byte_position      <= '0;
      line_count         <= 16'd1;
      column_count       <= 16'd1;
      tokens_emitted     <= '0;
    end else if (accept) begin
      mode               <= mode_next;
      pending_char       <= pending_char_next;
      token_start        <= token_start_next;
      token_len_count    <= token_len_count_next;
      token_start_column <= token_start_column_next;
      keyword_prefix     <= keyword_prefix_next;
      starts_upper       <= starts_upper_next;
      byte_position      <= byte_position_next;
      line_count         <= line_count_next;
      column_count       <= column_count_next;
      tokens_emitted     <= tokens_emitted_next;
    end
  end

endmodule

>>> src/slt_queue.sv
module slt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  slt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output slt_pkg::bundle_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  slt_pkg::bundle_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full       = (fill == (AW+1)'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> src/slt_back.sv
module slt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  slt_pkg::bundle_t  head,
  output logic              pop,
  output logic              token_valid,
  input  logic              token_ready,
  output slt_pkg::result_t  result
);

  logic [1:0] idx;
  logic       load;

  // take the next result once the output register frees up
  assign load = head_valid && (!token_valid || token_ready);
  assign pop  = load && (idx == head.count - 2'd1);

  always_ff @(posedge clk) begin
    if (load) result <= head.res[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      idx         <= '0;
    end else begin
      if (load) begin
        token_valid <= 1'b1;
        idx <= pop ? 2'd0 : idx + 2'd1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/script_lexer_tokenizer.sv
// Byte-stream lexer: takes one source byte per request and returns tokens with
// kind, offset, length, line, column and running number, closing each text with an
// end marker that carries the token total. The scanner classifies a byte and updates
// its state as the byte is accepted, so a byte can be taken every cycle; the results it causes
// (none to three) go into a four-entry queue and leave through an output register
// at one per cycle while token_ready holds. Sustained throughput is therefore one byte
// per cycle with a ready receiver, and lower where a byte causes more than one result;
// input stalls only when the queue is full. The first result a byte causes is written
// into the queue when the byte is accepted and then loaded into the output register.
module script_lexer_tokenizer #(
  parameter int MAX_TEXT_BYTES = slt_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic        is_token,
  output logic [5:0]  token_kind,
  output logic [15:0] token_offset,
  output logic [16:0] token_length,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic [16:0] token_index,
  output logic        unterminated_string,
  output logic        end_of_text
);

  slt_pkg::bundle_t bundle;
  slt_pkg::bundle_t head;
  slt_pkg::result_t result;
  logic             full;
  logic             accept;
  logic             head_valid;
  logic             pop;

  assign text_ready = !full;
  assign accept     = text_valid && text_ready;

  slt_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .bundle    (bundle)
  );

  slt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && (bundle.count != 2'd0)),
    .push_data  (bundle),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  slt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .result      (result)
  );

  assign is_token            = result.is_token;
  assign token_kind          = result.kind;
  assign token_offset        = result.offset;
  assign token_length        = result.length;
  assign token_line          = result.line;
  assign token_column        = result.column;
  assign token_index         = result.number;
  assign unterminated_string = result.unterm;
  assign end_of_text         = result.eot;

endmodule

>>> tb/sv/script_lexer_tokenizer_tb.sv
module script_lexer_tokenizer_tb;

  localparam int unsigned TEXT_CAP = slt_pkg::MAX_TEXT_BYTES_DEF;
  localparam int unsigned SAT_16 = 65535;

  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_INT, SC_FRAC, SC_ESIGN, SC_EDIG, SC_STR, SC_ESC, SC_PEND, SC_CMT
  } scan_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         pause;
    bit         calm;
  } text_req_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        text_valid = 0;
  logic        text_ready;
  logic [7:0]  text_byte = 0;
  logic        last_byte = 0;
  logic        token_valid;
  logic        token_ready = 0;
  logic        is_token;
  logic [5:0]  token_kind;
  logic [15:0] token_offset;
  logic [16:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [16:0] token_index;
  logic        unterminated_string;
  logic        end_of_text;

  script_lexer_tokenizer dut (.*);

  text_req_t        text_q[$];
  slt_pkg::result_t token_q[$];
  int        errors = 0;
  int        bytes_sent = 0;
  int        tokens_seen = 0;
  int        texts_seen = 0;
  bit        mark_pause = 0;
  bit        calm_mode = 0;
  bit        calm_now = 0;
  int        tx_gap = 0;
  int        rx_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 0;

  // scanner copy
  scan_t       lx_mode;
  logic [7:0]  lx_pend;
  int unsigned lx_start, lx_len, lx_tcol, lx_pos, lx_line, lx_col, lx_ntok;
  logic [7:0]  lx_kw[5];
  bit          lx_upper;
  int          lx_n;

  initial forever #5 clk = ~clk;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_up(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction
  function automatic bit id_first(logic [7:0] c);
    return is_up(c) || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic [5:0] one_char_kind(logic [7:0] c);
    case (c)
      "(": return slt_pkg::K_LPAREN;  ")": return slt_pkg::K_RPAREN;
      "{": return slt_pkg::K_LBRACE;  "}": return slt_pkg::K_RBRACE;
      "[": return slt_pkg::K_LBRACK;  "]": return slt_pkg::K_RBRACK;
      ",": return slt_pkg::K_COMMA;   ";": return slt_pkg::K_SEMI;
      ":": return slt_pkg::K_COLON;   "=": return slt_pkg::K_ASSIGN;
      "<": return slt_pkg::K_LT;      ">": return slt_pkg::K_GT;
      "+": return slt_pkg::K_PLUS;    "-": return slt_pkg::K_MINUS;
      "*": return slt_pkg::K_STAR;    "/": return slt_pkg::K_SLASH;
      "!": return slt_pkg::K_NOT;
      default: return slt_pkg::K_UNKNOWN;
    endcase
  endfunction

  // K_VAR doubles as "no pair"
  function automatic logic [5:0] two_char_kind(logic [7:0] p, logic [7:0] c);
    if (p == ":" && c == "=") return slt_pkg::K_DEFINE;
    if (p == "=" && c == "=") return slt_pkg::K_EQ;
    if (p == "!" && c == "=") return slt_pkg::K_NE;
    if (p == "<" && c == "=") return slt_pkg::K_LE;
    if (p == ">" && c == "=") return slt_pkg::K_GE;
    if (p == "&" && c == "&") return slt_pkg::K_AND;
    if (p == "|" && c == "|") return slt_pkg::K_OR;
    return slt_pkg::K_VAR;
  endfunction

  function automatic logic [5:0] word_kind();
    if (lx_len == 3 && {lx_kw[0], lx_kw[1], lx_kw[2]} == "var") return slt_pkg::K_VAR;
    if (lx_len == 2 && {lx_kw[0], lx_kw[1]} == "if") return slt_pkg::K_IF;
    if (lx_len == 4 && {lx_kw[0], lx_kw[1], lx_kw[2], lx_kw[3]} == "else")
      return slt_pkg::K_ELSE;
    if (lx_len == 4 && {lx_kw[0], lx_kw[1], lx_kw[2], lx_kw[3]} == "true")
      return slt_pkg::K_TRUE;
    if (lx_len == 5 && {lx_kw[0], lx_kw[1], lx_kw[2], lx_kw[3], lx_kw[4]} == "false")
      return slt_pkg::K_FALSE;
    return lx_upper ? slt_pkg::K_TYPE : slt_pkg::K_IDENT;
  endfunction

  function automatic int unsigned sat_up(int unsigned v);
    return v < TEXT_CAP ? v + 1 : v;
  endfunction

  task automatic lexer_clear();
    lx_mode = SC_IDLE; lx_pend = 0; lx_start = 0; lx_len = 0; lx_tcol = 1;
    foreach (lx_kw[i]) lx_kw[i] = 0;
    lx_upper = 0; lx_pos = 0; lx_line = 1; lx_col = 1; lx_ntok = 0;
  endtask

  task automatic col_up();
    if (lx_col < SAT_16) lx_col++;
  endtask

  task automatic line_up();
    if (lx_line < SAT_16) lx_line++;
    lx_col = 1;
  endtask

  task automatic emit_token(logic [5:0] kind, bit unterm);
    slt_pkg::result_t r;
    r.is_token = 1; r.kind = kind; r.offset = lx_start[15:0]; r.length = lx_len[16:0];
    r.line = lx_line[15:0]; r.column = lx_tcol[15:0]; r.number = lx_ntok[16:0];
    r.unterm = unterm; r.eot = 0;
    token_q.push_back(r);
    lx_n++;
    lx_ntok = sat_up(lx_ntok);
    lx_mode = SC_IDLE;
  endtask

  task automatic open_token(scan_t m);
    lx_start = lx_pos; lx_tcol = lx_col; lx_len = 1; lx_mode = m;
    col_up();
  endtask

  task automatic extend();
    lx_len = sat_up(lx_len);
    col_up();
  endtask

  task automatic start_fresh(logic [7:0] c);
    if (c == " " || (c >= 9 && c <= 13)) begin
      if (c == 8'h0a) line_up();
      else col_up();
    end else if (id_first(c)) begin
      foreach (lx_kw[i]) lx_kw[i] = 0;
      lx_kw[0] = c;
      lx_upper = is_up(c);
      open_token(SC_IDENT);
    end else if (is_dig(c)) begin
      open_token(SC_INT);
    end else if (c inside {"-", ":", "=", "!", "<", ">", "&", "|"}) begin
      lx_pend = c;
      open_token(SC_PEND);
    end else if (c == "\"") begin
      open_token(SC_STR);
    end else if (c == "#") begin
      lx_mode = SC_CMT;
    end else begin
      open_token(SC_IDLE);
      emit_token(one_char_kind(c), 0);
    end
  endtask

  task automatic lex_byte(logic [7:0] c, logic last);
    bit               taken;
    logic [5:0]       pk;
    slt_pkg::result_t m;
    taken = 1;
    lx_n = 0;
    if (lx_mode == SC_PEND) begin
      pk = two_char_kind(lx_pend, c);
      if (lx_pend == "-" && is_dig(c)) lx_mode = SC_INT;
      else if (pk != slt_pkg::K_VAR) begin
        extend();
        emit_token(pk, 0);
      end else begin
        emit_token(one_char_kind(lx_pend), 0);
        taken = 0;
      end
    end
    case (lx_mode)
      SC_IDENT: begin
        if (id_first(c) || is_dig(c)) begin
          if (lx_len < 5) lx_kw[lx_len] = c;
          extend();
        end else begin
          emit_token(word_kind(), 0);
          taken = 0;
        end
      end
      SC_INT, SC_FRAC, SC_ESIGN, SC_EDIG: begin
        if (is_dig(c)) begin
          if (lx_mode == SC_ESIGN) lx_mode = SC_EDIG;
          extend();
        end else if (c == "." && lx_mode == SC_INT) begin
          lx_mode = SC_FRAC;
          extend();
        end else if ((c == "e" || c == "E") && (lx_mode == SC_INT || lx_mode == SC_FRAC)) begin
          lx_mode = SC_ESIGN;
          extend();
        end else if ((c == "+" || c == "-") && lx_mode == SC_ESIGN) begin
          lx_mode = SC_EDIG;
          extend();
        end else begin
          emit_token(slt_pkg::K_NUMBER, 0);
          taken = 0;
        end
      end
      SC_STR: begin
        extend();
        if (c == "\"") emit_token(slt_pkg::K_STRING, 0);
        else if (c == "\\") lx_mode = SC_ESC;
      end
      SC_ESC: begin
        // escaped byte grows the token but not the column
        lx_len = sat_up(lx_len);
        lx_mode = SC_STR;
      end
      SC_CMT: begin
        if (c == 8'h0a) begin
          line_up();
          lx_mode = SC_IDLE;
        end
      end
      default: if (taken && lx_mode == SC_IDLE && lx_n == 0) taken = 0;
    endcase
    if (!taken) start_fresh(c);
    if (lx_pos < TEXT_CAP - 1) lx_pos++;
    if (last) begin
      case (lx_mode)
        SC_IDENT: emit_token(word_kind(), 0);
        SC_INT, SC_FRAC, SC_ESIGN, SC_EDIG: emit_token(slt_pkg::K_NUMBER, 0);
        SC_STR, SC_ESC: emit_token(slt_pkg::K_STRING, 1);
        SC_PEND: emit_token(one_char_kind(lx_pend), 0);
        default: ;
      endcase
      m = '0;
      m.number = lx_ntok[16:0];
      m.eot = 1;
      token_q.push_back(m);
      lexer_clear();
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             tokens_seen);
    errors++;
  endtask

  task automatic put(logic [7:0] b, logic last = 1'b0);
    text_q.push_back('{b, last, mark_pause, calm_mode});
    mark_pause = 0;
  endtask

  task automatic put_text(string s);
    foreach (s[i]) put(s[i], i == s.len() - 1);
  endtask

  task automatic put_str(string s);
    foreach (s[i]) put(s[i]);
  endtask

  task automatic put_token();
    string syms, pairs, kws[5];
    int    n;
    syms = "(){}[],;:=<>+-*/!";
    pairs = ":===!=<=>=&&||";
    kws = '{"var", "if", "else", "true", "false"};
    case ($urandom_range(0, 13))
      0, 1: put_str(kws[$urandom_range(0, 4)]);
      2, 3: begin
        n = $urandom_range(1, 7);
        put($urandom_range(0, 2) == 0 ? "_" : 8'($urandom_range("a", "z")));
        repeat (n - 1) put($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9"))
                                                     : 8'($urandom_range("a", "z")));
      end
      4: begin
        put(8'($urandom_range("A", "Z")));
        repeat ($urandom_range(0, 4)) put(8'($urandom_range("a", "z")));
      end
      5, 6: begin
        if ($urandom_range(0, 3) == 0) put("-");
        repeat ($urandom_range(1, 3)) put(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 1)) begin put("."); put(8'($urandom_range("0", "9"))); end
        if ($urandom_range(0, 1)) begin
          put($urandom_range(0, 1) ? "e" : "E");
          if ($urandom_range(0, 1)) put($urandom_range(0, 1) ? "+" : "-");
          put(8'($urandom_range("0", "9")));
        end
      end
      7: begin
        put("\"");
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: begin put("\\"); put($urandom_range(0, 1) ? "\"" : "n"); end
            1: put(8'h0a);
            default: put($urandom_range(" ", "~") == "\"" ? "x" : 8'($urandom_range("a", "z")));
          endcase
        end
        if ($urandom_range(0, 7) != 0) put("\"");
      end
      8: put(syms[$urandom_range(0, syms.len() - 1)]);
      9: begin
        n = 2 * $urandom_range(0, 6);
        put(pairs[n]); put(pairs[n + 1]);
      end
      10: begin
        put("#");
        repeat ($urandom_range(0, 4))
          put($urandom_range(0, 255) == 8'h0a ? "z" : 8'($urandom_range(32, 255)));
        put(8'h0a);
      end
      11: put($urandom_range(0, 1) ? "&" : "|");
      12: put(8'($urandom_range(0, 255)));
      default: put($urandom_range(0, 3) == 0 ? 8'h0a : " ");
    endcase
    if ($urandom_range(0, 2) == 0) put($urandom_range(0, 5) == 0 ? 8'h09 : " ");
  endtask

  initial begin
    int    rand_bytes;
    string tails;
    tails = "a7\"<\\F-#";
    // directed texts
    put_text("var if else true false Foo _x9 varx\n");
    put_text("-5 -x 1.25e+3 7E9 4e- := == != <= >= && || & | @");
    put_text("\"a\\\"b\nc\" # note\nx");
    put_text("\"open\\");
    put_text(">");
    put(8'h80); put(8'hff, 1'b1);
    // random texts
    rand_bytes = text_q.size();
    while (text_q.size() - rand_bytes < 370) begin
      if (!calm_mode && text_q.size() - rand_bytes > 180 && !hold_done) mark_pause = 1;
      if (text_q.size() - rand_bytes > 320) calm_mode = 1;
      repeat ($urandom_range(2, 10)) put_token();
      if ($urandom_range(0, 1)) put(8'($urandom_range(0, 255)), 1'b1);
      else put(tails[$urandom_range(0, tails.len() - 1)], 1'b1);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
  end

  // sender
  always @(posedge clk) begin : drive
    if (rst) begin
      text_valid <= 0;
    end else begin
      if (text_valid && text_ready) begin
        lex_byte(text_byte, last_byte);
        bytes_sent++;
      end
      if (!text_valid || text_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          text_valid <= 0;
        end else if (text_q.size() == 0) begin
          text_valid <= 0;
        end else if (text_q[0].pause && token_q.size() != 0) begin
          text_valid <= 0;
        end else if (!text_q[0].calm && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(1, 4) - 1;
          text_valid <= 0;
        end else begin
          text_valid <= 1;
          text_byte <= text_q[0].b;
          last_byte <= text_q[0].last;
          calm_now = text_q[0].calm;
          void'(text_q.pop_front());
        end
      end
    end
  end

  // long receiver stall so the result queue fills and the input backs up
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (!hold_done && tokens_seen >= 60) begin
      hold_left <= 200;
      hold_done <= 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch
    slt_pkg::result_t w;
    if (rst) begin
      token_ready <= 0;
    end else begin
      if (token_valid && token_ready) begin
        if (token_q.size() == 0) begin
          report("unexpected result number", token_index, 0);
        end else begin
          w = token_q.pop_front();
          if (is_token !== w.is_token) report("is_token", is_token, w.is_token);
          if (token_kind !== w.kind) report("kind", token_kind, w.kind);
          if (token_offset !== w.offset) report("offset", token_offset, w.offset);
          if (token_length !== w.length) report("length", token_length, w.length);
          if (token_line !== w.line) report("line", token_line, w.line);
          if (token_column !== w.column) report("column", token_column, w.column);
          if (token_index !== w.number) report("index", token_index, w.number);
          if (unterminated_string !== w.unterm)
            report("unterminated", unterminated_string, w.unterm);
          if (end_of_text !== w.eot) report("end_of_text", end_of_text, w.eot);
          if (w.eot) texts_seen++;
        end
        tokens_seen++;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        token_ready <= 0;
      end else if (!calm_now && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 4) - 1;
        token_ready <= 0;
      end else begin
        token_ready <= (hold_left == 0);
      end
    end
  end

  initial begin
    lexer_clear();
    @(negedge rst);
    do @(posedge clk);
    while (text_q.size() != 0 || text_valid || token_q.size() != 0);
    repeat (20) @(posedge clk);
    if (token_q.size() != 0) report("results outstanding", token_q.size(), 0);
    $display("Lexed %0d bytes in %0d texts, checked %0d results (keywords, numbers,",
             bytes_sent, texts_seen, tokens_seen);
    $display("strings, operators, comments, flushes and stalls); %0d errors", errors);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d requests and %0d results outstanding",
             text_q.size(), token_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
